>>> sv/ffc_pkg.sv
// package for the float format converter: function codes and format constants
// no dependencies; imported by float_format_converter_unit

package ffc_pkg;

    typedef enum logic [1:0] {
        FUNC_H2S  = 2'd0,
        FUNC_S2H  = 2'd1,
        FUNC_S2BF = 2'd2
    } func_t;

    localparam int unsigned FuncWidth    = 2;
    localparam int unsigned OperandWidth = 32;
    localparam int unsigned ResultWidth  = 32;

    // binary16 fields
    localparam logic [15:0] H_SIGN_MASK  = 16'h8000;
    localparam logic [15:0] H_INF        = 16'h7C00;
    localparam logic [15:0] H_QNAN       = 16'h7E00;
    localparam logic [12:0] H_ROUND_HALF = 13'h1000;

    // binary32 fields
    localparam logic [31:0] S_QUIET_BIT  = 32'h0040_0000;
    localparam logic [23:0] S_HIDDEN_BIT = 24'h80_0000;
    localparam logic [7:0]  S_EXP_MAX    = 8'hFF;
    localparam logic [7:0]  SUB_EXP_BASE = 8'd113;
    localparam logic [7:0]  EXP_BIAS_D   = 8'd112;

    // bfloat16
    localparam logic [31:0] BF_ROUND     = 32'h0000_7FFF;
    localparam logic [15:0] BF_QUIET_BIT = 16'h0040;

endpackage

>>> sv/float_format_converter_unit.sv
// top level of the float format converter: binary16/binary32/bfloat16 conversion
// depends on ffc_pkg

//  channel | signals                       | direction | content
//  --------+-------------------------------+-----------+------------------------------
//  in      | in_valid, in_stall, func,     | in        | function code and operand
//          | operand                       |           |
//  out     | out_valid, out_stall, result  | out       | converted bit pattern
//
//  one transaction per cycle sustained while out_stall is low; an accepted
//  input passes through the input register, then the result register
//  the conversion is a single pass of combinational logic between the two
//  registers; the leading-zero count and the rounding add set the path
//  rst_n clears both valid flags; payload registers are not reset
//  out_stall holds the result register; in_stall rises only when the input
//  register holds a transaction that cannot move into the result register

module float_format_converter_unit #(
    parameter int unsigned OperandW = ffc_pkg::OperandWidth,
    parameter int unsigned ResultW  = ffc_pkg::ResultWidth
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [ffc_pkg::FuncWidth-1:0] func,
    input  logic [OperandW-1:0]           operand,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [ResultW-1:0]            result
);

    import ffc_pkg::*;

    // pipeline registers
    logic                 s1_valid_reg, s1_valid_next;
    logic [FuncWidth-1:0] s1_func_reg;
    logic [OperandW-1:0]  s1_operand_reg;
    logic                 s2_valid_reg, s2_valid_next;
    logic [ResultW-1:0]   s2_result_reg, s2_result_next;

    logic s2_load;
    logic s1_load;

    // converter outputs
    logic [31:0] wide_res;
    logic [15:0] half_res;
    logic [15:0] bf_res;
    logic [31:0] conv_res;
    logic [31:0] op32;

    // result register takes a new transaction when empty or being drained
    assign s2_load  = !s2_valid_reg || !out_stall;
    assign in_stall = s1_valid_reg && !s2_load;
    assign s1_load  = in_valid && !in_stall;

    assign s1_valid_next = s1_load || (s1_valid_reg && !s2_load);
    assign s2_valid_next = s2_load ? s1_valid_reg : s2_valid_reg;

    assign op32 = 32'(s1_operand_reg);

    // binary16 -> binary32
    always_comb
    begin
        logic        h_sign;
        logic [4:0]  h_exp;
        logic [9:0]  h_man;
        logic [3:0]  msb_pos;
        logic [3:0]  lz;
        logic [10:0] norm;
        logic [7:0]  sub_exp;
        h_sign  = op32[15];
        h_exp   = op32[14:10];
        h_man   = op32[9:0];
        msb_pos = 4'd0;
        // highest set mantissa bit
        for (int i = 0; i < 10; i++)
        begin
            if (h_man[i])
            begin
                msb_pos = 4'(i);
            end
        end
        lz      = 4'd10 - msb_pos;
        norm    = {1'b0, h_man} << lz;
        sub_exp = SUB_EXP_BASE - {4'b0, lz};
        if (h_exp == 5'd0)
        begin
            if (h_man == 10'd0)
            begin
                wide_res = {h_sign, 31'd0};
            end
            else
            begin
                wide_res = {h_sign, sub_exp, norm[9:0], 13'd0};
            end
        end
        else if (h_exp == 5'h1F)
        begin
            wide_res = {h_sign, S_EXP_MAX, h_man, 13'd0};
            if (h_man != 10'd0)
            begin
                wide_res = wide_res | S_QUIET_BIT;
            end
        end
        else
        begin
            wide_res = {h_sign, {3'b0, h_exp} + EXP_BIAS_D, h_man, 13'd0};
        end
    end

    // binary32 -> binary16, round to nearest even
    always_comb
    begin
        logic [15:0]       sign16;
        logic [7:0]        s_exp;
        logic [22:0]       s_man;
        logic signed [9:0] e;
        logic signed [9:0] sh_full;
        logic [4:0]        sh;
        logic [15:0]       norm_r;
        logic [12:0]       low;
        logic [23:0]       sig;
        logic [23:0]       q;
        logic [23:0]       rem;
        logic [23:0]       half;
        sign16  = op32[31] ? H_SIGN_MASK : 16'd0;
        s_exp   = op32[30:23];
        s_man   = op32[22:0];
        e       = $signed({2'b00, s_exp}) - 10'sd112;
        sh_full = 10'sd14 - e;
        sh      = sh_full[4:0];
        norm_r  = sign16 | {1'b0, e[4:0], s_man[22:13]};
        low     = s_man[12:0];
        sig     = {1'b0, s_man} | S_HIDDEN_BIT;
        q       = sig >> sh;
        rem     = sig & ~(24'hFF_FFFF << sh);
        half    = 24'd1 << (sh - 5'd1);
        if (s_exp == S_EXP_MAX)
        begin
            if (s_man == 23'd0)
            begin
                half_res = sign16 | H_INF;
            end
            else
            begin
                half_res = sign16 | H_QNAN | {7'd0, s_man[21:13]};
            end
        end
        else if (e >= 10'sd31)
        begin
            half_res = sign16 | H_INF;
        end
        else if (e >= 10'sd1)
        begin
            // rounding carry may reach the next exponent or infinity
            if (low > H_ROUND_HALF || (low == H_ROUND_HALF && norm_r[0]))
            begin
                half_res = norm_r + 16'd1;
            end
            else
            begin
                half_res = norm_r;
            end
        end
        else if (e < -10'sd10)
        begin
            half_res = sign16;
        end
        else
        begin
            // subnormal output
            if (rem > half || (rem == half && q[0]))
            begin
                q = q + 24'd1;
            end
            half_res = sign16 | q[15:0];
        end
    end

    // binary32 -> bfloat16, round to nearest even
    always_comb
    begin
        logic [31:0] sum;
        sum = op32 + BF_ROUND + {31'd0, op32[16]};
        if (op32[30:23] == S_EXP_MAX && op32[22:0] != 23'd0)
        begin
            bf_res = op32[31:16] | BF_QUIET_BIT;
        end
        else
        begin
            bf_res = sum[31:16];
        end
    end

    always_comb
    begin
        case (func_t'(s1_func_reg))
            FUNC_H2S:  conv_res = wide_res;
            FUNC_S2H:  conv_res = {16'd0, half_res};
            FUNC_S2BF: conv_res = {16'd0, bf_res};
            default:   conv_res = 32'd0;
        endcase
    end

    assign s2_result_next = ResultW'(conv_res);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_load)
        begin
            s1_func_reg    <= func;
            s1_operand_reg <= operand;
        end
        if (s2_load && s1_valid_reg)
        begin
            s2_result_reg <= s2_result_next;
        end
    end

    assign out_valid = s2_valid_reg;
    assign result    = s2_result_reg;

endmodule
